// ===== rtl/snns_pkg.sv =====
// Shared constants for the 5-smooth neighbor search block.
// No dependencies.
package snns_pkg;

    localparam int VALUE_BITS_DEF  = 32;
    localparam int TABLE_DEPTH_DEF = 2048;

    localparam int QUERY_W  = 32;
    localparam int WIDE_W   = 33;
    localparam int NARROW_W = 32;

endpackage

// ===== rtl/snns_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
module snns_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 2048,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== rtl/snns_fill.sv =====
// Table builder: after reset writes the ascending 5-smooth numbers into the RAM,
// reading back earlier entries through one RAM read port. Depends on snns_pkg.
module snns_fill #(
    parameter int VALUE_BITS = snns_pkg::VALUE_BITS_DEF,
    parameter int DEPTH      = snns_pkg::TABLE_DEPTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int EW        = VALUE_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [EW-1:0] o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [EW-1:0] i_rdata,
    output logic          o_done,
    output logic [CW-1:0] o_count,
    output logic [EW-1:0] o_last
);

    localparam int GW = VALUE_BITS + 3;
    localparam logic [GW-1:0] LIMIT = GW'(1) << VALUE_BITS;

    typedef enum logic [4:0] {
        F_INIT  = 5'b00001,
        F_GEN   = 5'b00010,
        F_RADDR = 5'b00100,
        F_RDATA = 5'b01000,
        F_DONE  = 5'b10000
    } t_fill_state;

    t_fill_state   r_state, n_state;
    logic [GW-1:0] r_c2, r_c3, r_c5, n_c2, n_c3, n_c5;
    logic [AW-1:0] r_p2, r_p3, r_p5, n_p2, n_p3, n_p5;
    logic [CW-1:0] r_n, n_n;
    logic [EW-1:0] r_last, n_last;
    logic [2:0]    r_ld, n_ld, r_sel, n_sel;
    logic [2:0]    w_first;
    logic [GW-1:0] w_min23, w_min, w_rd;

    always_comb begin
        w_min23 = (r_c2 < r_c3) ? r_c2 : r_c3;
        w_min   = (w_min23 < r_c5) ? w_min23 : r_c5;
        w_first = r_ld & (~r_ld + 3'd1);
        w_rd    = GW'(i_rdata);

        n_state = r_state;
        n_c2    = r_c2;
        n_c3    = r_c3;
        n_c5    = r_c5;
        n_p2    = r_p2;
        n_p3    = r_p3;
        n_p5    = r_p5;
        n_n     = r_n;
        n_last  = r_last;
        n_ld    = r_ld;
        n_sel   = r_sel;
        o_we    = 1'b0;
        o_waddr = r_n[AW-1:0];
        o_wdata = w_min[EW-1:0];
        o_raddr = r_p2;

        unique case (r_state)
            F_INIT: begin
                o_we    = 1'b1;
                o_waddr = '0;
                o_wdata = EW'(1);
                n_n     = CW'(1);
                n_p2    = '0;
                n_p3    = '0;
                n_p5    = '0;
                n_c2    = GW'(2);
                n_c3    = GW'(3);
                n_c5    = GW'(5);
                n_last  = EW'(1);
                n_ld    = '0;
                n_state = F_GEN;
            end
            F_GEN: begin
                if (r_n == CW'(DEPTH) || w_min > LIMIT) begin
                    n_state = F_DONE;
                end else begin
                    o_we    = 1'b1;
                    n_n     = r_n + CW'(1);
                    n_last  = w_min[EW-1:0];
                    n_ld    = {r_c5 == w_min, r_c3 == w_min, r_c2 == w_min};
                    n_state = F_RADDR;
                end
            end
            F_RADDR: begin
                n_sel = w_first;
                n_ld  = r_ld & ~w_first;
                if (w_first[0]) begin
                    o_raddr = r_p2 + AW'(1);
                    n_p2    = r_p2 + AW'(1);
                end else if (w_first[1]) begin
                    o_raddr = r_p3 + AW'(1);
                    n_p3    = r_p3 + AW'(1);
                end else begin
                    o_raddr = r_p5 + AW'(1);
                    n_p5    = r_p5 + AW'(1);
                end
                n_state = F_RDATA;
            end
            F_RDATA: begin
                if (r_sel[0]) begin
                    n_c2 = w_rd << 1;
                end else if (r_sel[1]) begin
                    n_c3 = (w_rd << 1) + w_rd;
                end else begin
                    n_c5 = (w_rd << 2) + w_rd;
                end
                n_state = (r_ld != '0) ? F_RADDR : F_GEN;
            end
            F_DONE: begin
                n_state = F_DONE;
            end
            default: begin
                n_state = F_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_INIT;
            r_ld    <= '0;
        end else begin
            r_state <= n_state;
            r_ld    <= n_ld;
        end
        r_c2   <= n_c2;
        r_c3   <= n_c3;
        r_c5   <= n_c5;
        r_p2   <= n_p2;
        r_p3   <= n_p3;
        r_p5   <= n_p5;
        r_n    <= n_n;
        r_last <= n_last;
        r_sel  <= n_sel;
    end

    assign o_done  = (r_state == F_DONE);
    assign o_count = r_n;
    assign o_last  = r_last;

endmodule

// ===== rtl/snns_search.sv =====
// Query engine: two binary searches over the table RAM in lockstep, neighbor
// fetch, candidate select and nearest compare. Depends on snns_pkg.
module snns_search #(
    parameter int VALUE_BITS = snns_pkg::VALUE_BITS_DEF,
    parameter int DEPTH      = snns_pkg::TABLE_DEPTH_DEF,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int EW        = VALUE_BITS + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tbl_ready,
    input  logic [CW-1:0]                  i_count,
    input  logic [EW-1:0]                  i_last,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [snns_pkg::QUERY_W-1:0]   i_query_value,
    output logic [AW-1:0]                  o_raddr_a,
    output logic [AW-1:0]                  o_raddr_b,
    input  logic [EW-1:0]                  i_rdata_a,
    input  logic [EW-1:0]                  i_rdata_b,
    output logic                           o_valid,
    output logic [snns_pkg::WIDE_W-1:0]    o_next_larger,
    output logic [snns_pkg::NARROW_W-1:0]  o_next_smaller,
    output logic [snns_pkg::WIDE_W-1:0]    o_nearest_smooth,
    output logic [snns_pkg::WIDE_W-1:0]    o_next_larger_even,
    output logic [snns_pkg::NARROW_W-1:0]  o_next_smaller_even,
    output logic [snns_pkg::WIDE_W-1:0]    o_nearest_even,
    output logic                           o_query_is_smooth
);

    localparam int XW = CW + 1;
    localparam int BW = $clog2(CW);
    localparam int WW = snns_pkg::WIDE_W;
    localparam int NW = snns_pkg::NARROW_W;
    localparam logic [1:0] FETCH_LAST = 2'd2;
    localparam logic [EW-1:0] ONE = EW'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SRCH  = 6'b000010,
        S_FETCH = 6'b000100,
        S_TAIL  = 6'b001000,
        S_SEL   = 6'b010000,
        S_CALC  = 6'b100000
    } t_srch_state;

    t_srch_state     r_state, n_state;
    logic [VALUE_BITS-1:0] r_q, r_h;
    logic            r_qc_odd;
    logic [CW-1:0]   r_pos_a, r_pos_b;
    logic [XW-1:0]   r_cand_a, r_cand_b;
    logic            r_inr_a, r_inr_b, r_probe;
    logic [BW-1:0]   r_bit;
    logic [1:0]      r_k;
    logic [EW-1:0]   r_au, r_a1, r_a2, r_bu, r_b1, r_b2;
    logic [EW-1:0]   r_up, r_floor, r_down, r_upe, r_downe;
    logic            r_hf, r_hit;
    logic            r_valid;
    logic [WW-1:0]   r_o_nl, r_o_near, r_o_nle, r_o_neare;
    logic [NW-1:0]   r_o_ns, r_o_nse;
    logic            r_o_hit;

    logic            w_acc, w_shift;
    logic [EW-1:0]   w_qx, w_qc;
    logic            w_ok_a, w_ok_b, w_last_step;
    logic [CW-1:0]   w_pos_a, w_pos_b;
    logic [BW-1:0]   w_bit_nx;
    logic [XW-1:0]   w_cand_a, w_cand_b, w_cm1_a, w_cm1_b;
    logic            w_hit, w_hf, w_ex;
    logic [EW-1:0]   w_up, w_down, w_upe, w_downe, w_t;
    logic [EW-1:0]   w_rq, w_d_up, w_d_fl, w_d_ue, w_d_de, w_near, w_neare;

    assign o_busy = !i_tbl_ready || (r_state != S_IDLE);
    assign w_acc  = i_start && !o_busy;

    always_comb begin
        w_qx = EW'(i_query_value[VALUE_BITS-1:0]);
        w_qc = (w_qx <= i_last) ? w_qx : i_last + ONE;

        // one probe per port per cycle
        w_ok_a      = r_inr_a && (i_rdata_a <= EW'(r_q));
        w_ok_b      = r_inr_b && (i_rdata_b <= EW'(r_h));
        w_pos_a     = (r_probe && w_ok_a) ? r_cand_a[CW-1:0] : r_pos_a;
        w_pos_b     = (r_probe && w_ok_b) ? r_cand_b[CW-1:0] : r_pos_b;
        w_last_step = r_probe && (r_bit == '0);
        w_bit_nx    = r_probe ? r_bit - BW'(1) : r_bit;
        w_cand_a    = XW'(w_pos_a) + (XW'(1) << w_bit_nx);
        w_cand_b    = XW'(w_pos_b) + (XW'(1) << w_bit_nx);
        w_cm1_a     = w_cand_a - XW'(1);
        w_cm1_b     = w_cand_b - XW'(1);

        o_raddr_a = w_cm1_a[AW-1:0];
        o_raddr_b = w_cm1_b[AW-1:0];
        w_shift   = 1'b0;
        if (r_state == S_FETCH) begin
            o_raddr_a = r_pos_a[AW-1:0] - AW'(r_k);
            o_raddr_b = r_pos_b[AW-1:0] - AW'(r_k);
            w_shift   = (r_k != '0);
        end else if (r_state == S_TAIL) begin
            w_shift   = 1'b1;
        end

        // candidate select
        w_hf   = (r_pos_a != '0);
        w_hit  = w_hf && (r_a1 == EW'(r_q));
        w_up   = (r_pos_a < i_count) ? r_au : i_last;
        w_down = w_hit ? ((r_pos_a > CW'(1)) ? r_a2 : ONE) : (w_hf ? r_a1 : ONE);
        w_upe  = ((r_pos_b < i_count) && (r_bu <= EW'(i_last[EW-1:1])))
                 ? {r_bu[EW-2:0], 1'b0} : i_last;
        if (r_pos_b == '0) begin
            w_ex = 1'b0;
            w_t  = r_b1;
        end else if (r_qc_odd || (r_b1 != EW'(r_h))) begin
            w_ex = 1'b1;
            w_t  = r_b1;
        end else begin
            w_ex = (r_pos_b > CW'(1));
            w_t  = r_b2;
        end
        w_downe = w_ex ? {w_t[EW-2:0], 1'b0} : ONE;

        // nearest compare
        w_rq    = EW'(r_q);
        w_d_up  = (r_up > w_rq) ? r_up - w_rq : w_rq - r_up;
        w_d_fl  = w_rq - r_floor;
        w_d_ue  = (r_upe > w_rq) ? r_upe - w_rq : w_rq - r_upe;
        w_d_de  = (r_downe > w_rq) ? r_downe - w_rq : w_rq - r_downe;
        w_near  = (!r_hf || (w_d_up < w_d_fl)) ? r_up : r_floor;
        w_neare = (w_d_ue < w_d_de) ? r_upe : r_downe;

        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = w_acc ? S_SRCH : S_IDLE;
            S_SRCH:  n_state = w_last_step ? S_FETCH : S_SRCH;
            S_FETCH: n_state = (r_k == FETCH_LAST) ? S_TAIL : S_FETCH;
            S_TAIL:  n_state = S_SEL;
            S_SEL:   n_state = S_CALC;
            S_CALC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_probe <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_CALC);
            if (w_acc) begin
                r_probe <= 1'b0;
            end else if (r_state == S_SRCH) begin
                r_probe <= 1'b1;
            end
        end

        if (w_acc) begin
            r_q      <= i_query_value[VALUE_BITS-1:0];
            r_h      <= w_qc[EW-1:1];
            r_qc_odd <= w_qc[0];
            r_pos_a  <= '0;
            r_pos_b  <= '0;
            r_bit    <= BW'(CW - 1);
        end else if (r_state == S_SRCH) begin
            r_pos_a  <= w_pos_a;
            r_pos_b  <= w_pos_b;
            r_bit    <= w_bit_nx;
            r_cand_a <= w_cand_a;
            r_cand_b <= w_cand_b;
            r_inr_a  <= (w_cand_a <= XW'(i_count));
            r_inr_b  <= (w_cand_b <= XW'(i_count));
        end

        if (r_state == S_FETCH) begin
            r_k <= r_k + 2'd1;
        end else begin
            r_k <= '0;
        end

        if (w_shift) begin
            r_a2 <= i_rdata_a;
            r_a1 <= r_a2;
            r_au <= r_a1;
            r_b2 <= i_rdata_b;
            r_b1 <= r_b2;
            r_bu <= r_b1;
        end

        if (r_state == S_SEL) begin
            r_up    <= w_up;
            r_floor <= r_a1;
            r_hf    <= w_hf;
            r_hit   <= w_hit;
            r_down  <= w_down;
            r_upe   <= w_upe;
            r_downe <= w_downe;
        end

        if (r_state == S_CALC) begin
            r_o_nl    <= WW'(r_up);
            r_o_ns    <= NW'(r_down);
            r_o_near  <= WW'(w_near);
            r_o_nle   <= WW'(r_upe);
            r_o_nse   <= NW'(r_downe);
            r_o_neare <= WW'(w_neare);
            r_o_hit   <= r_hit;
        end
    end

    assign o_valid             = r_valid;
    assign o_next_larger       = r_o_nl;
    assign o_next_smaller      = r_o_ns;
    assign o_nearest_smooth    = r_o_near;
    assign o_next_larger_even  = r_o_nle;
    assign o_next_smaller_even = r_o_nse;
    assign o_nearest_even      = r_o_neare;
    assign o_query_is_smooth   = r_o_hit;

endmodule

// ===== rtl/smooth_number_neighbor_search.sv =====
// 5-smooth neighbor search, top level: table RAM, table builder and query engine.
// Depends on snns_pkg, snns_ram, snns_fill, snns_search.
//
// Usage:
//   Command channel: drive i_query_value and raise start; the transfer happens
//   at a rising edge where start is high and busy is low.
//   Result channel: o_valid pulses for one cycle with all seven result fields;
//   the receiver takes it at that edge and cannot stall it.
//   Busy drops in the same cycle that the result is shown, so the next query
//   may follow then; the block takes no new query while one is in flight.
//   Each query runs a binary search: one probe per cycle on each of the two
//   RAM read ports, one bit of the entry index per probe, then three neighbor
//   reads, a tail shift, a select step and a compare step.
//   Reset: the table builder writes the smooth numbers into the RAM, reading
//   back an earlier entry for each factor that the new entry advances, and
//   busy stays high meanwhile.
module smooth_number_neighbor_search #(
    parameter int VALUE_BITS         = snns_pkg::VALUE_BITS_DEF,
    parameter int SMOOTH_TABLE_DEPTH = snns_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [snns_pkg::QUERY_W-1:0]   i_query_value,
    output logic                           o_valid,
    output logic [snns_pkg::WIDE_W-1:0]    o_next_larger,
    output logic [snns_pkg::NARROW_W-1:0]  o_next_smaller,
    output logic [snns_pkg::WIDE_W-1:0]    o_nearest_smooth,
    output logic [snns_pkg::WIDE_W-1:0]    o_next_larger_even,
    output logic [snns_pkg::NARROW_W-1:0]  o_next_smaller_even,
    output logic [snns_pkg::WIDE_W-1:0]    o_nearest_even,
    output logic                           o_query_is_smooth
);

    localparam int AW = $clog2(SMOOTH_TABLE_DEPTH);
    localparam int CW = $clog2(SMOOTH_TABLE_DEPTH + 1);
    localparam int EW = VALUE_BITS + 1;

    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_fill_raddr, w_srch_raddr_a, w_srch_raddr_b, w_raddr_a;
    logic [EW-1:0] w_rdata_a, w_rdata_b;
    logic          w_tbl_ready;
    logic [CW-1:0] w_count;
    logic [EW-1:0] w_last;

    assign w_raddr_a = w_tbl_ready ? w_srch_raddr_a : w_fill_raddr;

    snns_fill #(
        .VALUE_BITS (VALUE_BITS),
        .DEPTH      (SMOOTH_TABLE_DEPTH)
    ) u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_fill_raddr),
        .i_rdata (w_rdata_a),
        .o_done  (w_tbl_ready),
        .o_count (w_count),
        .o_last  (w_last)
    );

    snns_ram #(
        .WIDTH (EW),
        .DEPTH (SMOOTH_TABLE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_srch_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    snns_search #(
        .VALUE_BITS (VALUE_BITS),
        .DEPTH      (SMOOTH_TABLE_DEPTH)
    ) u_search (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_tbl_ready         (w_tbl_ready),
        .i_count             (w_count),
        .i_last              (w_last),
        .i_start             (start),
        .o_busy              (busy),
        .i_query_value       (i_query_value),
        .o_raddr_a           (w_srch_raddr_a),
        .o_raddr_b           (w_srch_raddr_b),
        .i_rdata_a           (w_rdata_a),
        .i_rdata_b           (w_rdata_b),
        .o_valid             (o_valid),
        .o_next_larger       (o_next_larger),
        .o_next_smaller      (o_next_smaller),
        .o_nearest_smooth    (o_nearest_smooth),
        .o_next_larger_even  (o_next_larger_even),
        .o_next_smaller_even (o_next_smaller_even),
        .o_nearest_even      (o_nearest_even),
        .o_query_is_smooth   (o_query_is_smooth)
    );

endmodule

// ===== dv/smooth_number_neighbor_search_tb.sv =====
// Testbench for smooth_number_neighbor_search: sends query values, predicts the seven neighbor
// fields from its own table of 5-smooth numbers and checks each result strobe in order.
// Depends on snns_pkg and the smooth_number_neighbor_search RTL.
`timescale 1ns / 100ps

module smooth_number_neighbor_search_tb;

    localparam int QUERY_W        = snns_pkg::QUERY_W;
    localparam int WIDE_W         = snns_pkg::WIDE_W;
    localparam int NARROW_W       = snns_pkg::NARROW_W;
    localparam int SMOOTH_DEPTH   = 2048;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 60;
    localparam longint unsigned VALUE_LIMIT = 64'h1_0000_0000;

    typedef struct packed {
        logic [QUERY_W-1:0]  query;
        logic [WIDE_W-1:0]   larger;
        logic [NARROW_W-1:0] smaller;
        logic [WIDE_W-1:0]   nearest;
        logic [WIDE_W-1:0]   larger_even;
        logic [NARROW_W-1:0] smaller_even;
        logic [WIDE_W-1:0]   nearest_even;
        logic                is_smooth;
    } t_neighbor;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [QUERY_W-1:0]   i_query_value;
    logic                 o_valid;
    logic [WIDE_W-1:0]    o_next_larger;
    logic [NARROW_W-1:0]  o_next_smaller;
    logic [WIDE_W-1:0]    o_nearest_smooth;
    logic [WIDE_W-1:0]    o_next_larger_even;
    logic [NARROW_W-1:0]  o_next_smaller_even;
    logic [WIDE_W-1:0]    o_nearest_even;
    logic                 o_query_is_smooth;

    longint unsigned smooth_tbl[SMOOTH_DEPTH];
    int              smooth_cnt;
    t_neighbor       pending_neighbors[$];
    int              error_count;
    int              stall_cycles;
    bit              sender_idles;

    smooth_number_neighbor_search dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_query_value       (i_query_value),
        .o_valid             (o_valid),
        .o_next_larger       (o_next_larger),
        .o_next_smaller      (o_next_smaller),
        .o_nearest_smooth    (o_nearest_smooth),
        .o_next_larger_even  (o_next_larger_even),
        .o_next_smaller_even (o_next_smaller_even),
        .o_nearest_even      (o_nearest_even),
        .o_query_is_smooth   (o_query_is_smooth)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ascending 5-smooth numbers up to and including 2^32
    initial begin : table_build
        longint unsigned c2, c3, c5, m;
        int p2, p3, p5;
        p2 = 0;
        p3 = 0;
        p5 = 0;
        smooth_tbl[0] = 1;
        smooth_cnt = 1;
        while (smooth_cnt < SMOOTH_DEPTH) begin
            c2 = 2 * smooth_tbl[p2];
            c3 = 3 * smooth_tbl[p3];
            c5 = 5 * smooth_tbl[p5];
            m = c2;
            if (c3 < m) m = c3;
            if (c5 < m) m = c5;
            if (m > VALUE_LIMIT) break;
            smooth_tbl[smooth_cnt] = m;
            smooth_cnt++;
            if (c2 == m) p2++;
            if (c3 == m) p3++;
            if (c5 == m) p5++;
        end
    end

    function automatic longint unsigned abs_gap(input longint unsigned a,
                                                input longint unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic t_neighbor predict_neighbors(input logic [QUERY_W-1:0] q);
        t_neighbor r;
        longint unsigned qx, t, up, up_e, down, down_e, flr, near, near_e;
        bit have_up, have_up_e, have_flr, hit;
        qx = 64'(q);
        up = 0;
        up_e = 0;
        down = 1;
        down_e = 1;
        flr = 0;
        have_up = 0;
        have_up_e = 0;
        have_flr = 0;
        hit = 0;
        for (int i = 0; i < smooth_cnt; i++) begin
            t = smooth_tbl[i];
            if (t > qx) begin
                if (!have_up) begin
                    up = t;
                    have_up = 1;
                end
                if (t[0] == 1'b0 && !have_up_e) begin
                    up_e = t;
                    have_up_e = 1;
                end
                if (have_up && have_up_e) break;
            end else begin
                flr = t;
                have_flr = 1;
                if (t == qx) hit = 1;
                else begin
                    down = t;
                    if (t[0] == 1'b0) down_e = t;
                end
            end
        end
        if (!have_up) up = smooth_tbl[smooth_cnt-1];
        if (!have_up_e) up_e = smooth_tbl[smooth_cnt-1];
        if (!have_flr || abs_gap(up, qx) < abs_gap(qx, flr)) near = up;
        else near = flr;
        near_e = (abs_gap(up_e, qx) < abs_gap(down_e, qx)) ? up_e : down_e;
        r.query        = q;
        r.larger       = up[WIDE_W-1:0];
        r.smaller      = down[NARROW_W-1:0];
        r.nearest      = near[WIDE_W-1:0];
        r.larger_even  = up_e[WIDE_W-1:0];
        r.smaller_even = down_e[NARROW_W-1:0];
        r.nearest_even = near_e[WIDE_W-1:0];
        r.is_smooth    = hit;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [QUERY_W-1:0] q,
                                   input logic [WIDE_W-1:0] got, input logic [WIDE_W-1:0] want);
        error_count++;
        if (error_count <= 50)
            $display("%0t mismatch %s query=0x%08h got=0x%09h exp=0x%09h",
                     $realtime, field, q, got, want);
    endtask

    // an idle gap lets the current query finish, then holds start low a while
    task automatic send_query(input logic [QUERY_W-1:0] q);
        if (sender_idles && $urandom_range(0, 99) < 28) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy !== 1'b0);
            while ($urandom_range(0, 99) < 28) @(posedge i_clk);
        end
        start <= 1'b1;
        i_query_value <= q;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_neighbors.push_back(predict_neighbors(q));
    endtask

    function automatic logic [QUERY_W-1:0] pick_query();
        longint unsigned a, b, v;
        int idx;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 64);
            4, 5:    v = smooth_tbl[$urandom_range(0, smooth_cnt - 2)];
            6: begin
                v = smooth_tbl[$urandom_range(0, smooth_cnt - 2)];
                v = $urandom_range(0, 1) ? v + 1 : v - 1;
            end
            7: begin
                idx = $urandom_range(0, smooth_cnt - 3);
                v = (smooth_tbl[idx] + smooth_tbl[idx + 1]) / 2;
            end
            8: begin
                idx = $urandom_range(0, smooth_cnt - 3);
                while (smooth_tbl[idx][0]) idx++;
                a = smooth_tbl[idx];
                idx++;
                while (smooth_tbl[idx][0]) idx++;
                b = smooth_tbl[idx];
                v = (a + b) / 2;
            end
            default: v = 64'hFFFF_FFFF - $urandom_range(0, 1 << 20);
        endcase
        return v[QUERY_W-1:0];
    endfunction

    task automatic test_directed();
        logic [QUERY_W-1:0] corner_q[$] = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd11, 32'd12, 32'd13,
            32'd31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd4293273599,
            32'd4293273600, 32'd4293273601, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
            32'hAAAA_AAAA, 32'h5555_5555
        };
        foreach (corner_q[i]) send_query(corner_q[i]);
    endtask

    // sender holds off until every outstanding result is back
    task automatic test_drain_then_send();
        start <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        repeat (10) send_query(pick_query());
    endtask

    task automatic test_random_mix(input int count, input bit idles);
        sender_idles = idles;
        repeat (count) send_query(pick_query());
        sender_idles = 1'b1;
    endtask

    always @(posedge i_clk) begin : result_check
        t_neighbor want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_neighbors.size() == 0) begin
                report_mismatch("unexpected_result", '0, o_next_larger, '0);
            end else begin
                want = pending_neighbors.pop_front();
                if (o_valid !== 1'b1)
                    report_mismatch("valid", want.query, WIDE_W'(o_valid), WIDE_W'(1'b1));
                if (o_next_larger !== want.larger)
                    report_mismatch("next_larger", want.query, o_next_larger, want.larger);
                if (o_next_smaller !== want.smaller)
                    report_mismatch("next_smaller", want.query, WIDE_W'(o_next_smaller),
                                    WIDE_W'(want.smaller));
                if (o_nearest_smooth !== want.nearest)
                    report_mismatch("nearest_smooth", want.query, o_nearest_smooth,
                                    want.nearest);
                if (o_next_larger_even !== want.larger_even)
                    report_mismatch("next_larger_even", want.query, o_next_larger_even,
                                    want.larger_even);
                if (o_next_smaller_even !== want.smaller_even)
                    report_mismatch("next_smaller_even", want.query,
                                    WIDE_W'(o_next_smaller_even), WIDE_W'(want.smaller_even));
                if (o_nearest_even !== want.nearest_even)
                    report_mismatch("nearest_even", want.query, o_nearest_even,
                                    want.nearest_even);
                if (o_query_is_smooth !== want.is_smooth)
                    report_mismatch("query_is_smooth", want.query, WIDE_W'(o_query_is_smooth),
                                    WIDE_W'(want.is_smooth));
            end
        end
    end

    // cycles with neither a query transfer nor a result
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("smooth_number_neighbor_search_tb: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        error_count = 0;
        stall_cycles = 0;
        sender_idles = 1'b1;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_query_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_then_send();
        test_random_mix(300, 1'b0);
        test_random_mix(1100, 1'b1);

        start <= 1'b0;
        while (pending_neighbors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("smooth_number_neighbor_search_tb: clean");
        else
            $display("smooth_number_neighbor_search_tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/snns_pkg.sv
rtl/snns_ram.sv
rtl/snns_fill.sv
rtl/snns_search.sv
rtl/smooth_number_neighbor_search.sv
dv/smooth_number_neighbor_search_tb.sv
